>>> design/tcee_pkg.sv
// Package of the tracker channel effect engine.
// Holds the period table, channel state record and shared constants; no dependencies.
package tcee_pkg;

    localparam int CHANNELS   = 4;
    localparam int ROWS       = 64;
    localparam int SAMPLES    = 31;
    localparam int TABLE_SIZE = 48;
    localparam int ROM_ENTRIES = 48;
    localparam int TLEN = (TABLE_SIZE < ROM_ENTRIES) ? TABLE_SIZE : ROM_ENTRIES;
    localparam int IDX_W = 6;
    localparam int CH_W = 2;

    localparam logic [11:0] PERIOD_MIN = 12'd113;
    localparam logic [11:0] PERIOD_MAX = 12'd1712;
    localparam logic [6:0]  VOL_MAX    = 7'd64;

    localparam logic [3:0] EFF_ARP      = 4'h0;
    localparam logic [3:0] EFF_SLIDE_UP = 4'h1;
    localparam logic [3:0] EFF_SLIDE_DN = 4'h2;
    localparam logic [3:0] EFF_PORTA    = 4'h3;
    localparam logic [3:0] EFF_VIB      = 4'h4;
    localparam logic [3:0] EFF_PORTA_VS = 4'h5;
    localparam logic [3:0] EFF_VIB_VS   = 4'h6;
    localparam logic [3:0] EFF_TREM     = 4'h7;
    localparam logic [3:0] EFF_OFFSET   = 4'h9;
    localparam logic [3:0] EFF_VSLIDE   = 4'hA;
    localparam logic [3:0] EFF_JUMP     = 4'hB;
    localparam logic [3:0] EFF_VOL      = 4'hC;
    localparam logic [3:0] EFF_BREAK    = 4'hD;
    localparam logic [3:0] EFF_EXT      = 4'hE;
    localparam logic [3:0] EFF_SPEED    = 4'hF;

    localparam logic [3:0] EXT_FINE_UP = 4'h1;
    localparam logic [3:0] EXT_FINE_DN = 4'h2;
    localparam logic [3:0] EXT_LOOP    = 4'h6;
    localparam logic [3:0] EXT_RETRIG  = 4'h9;
    localparam logic [3:0] EXT_FVOL_UP = 4'hA;
    localparam logic [3:0] EXT_FVOL_DN = 4'hB;
    localparam logic [3:0] EXT_CUT     = 4'hC;
    localparam logic [3:0] EXT_DELAY   = 4'hD;
    localparam logic [3:0] EXT_PDELAY  = 4'hE;

    localparam logic [1:0] JUMP_NONE  = 2'd0;
    localparam logic [1:0] JUMP_POS   = 2'd1;
    localparam logic [1:0] JUMP_BREAK = 2'd2;
    localparam logic [1:0] JUMP_LOOP  = 2'd3;

    typedef struct packed {
        logic [11:0] period;
        logic [11:0] rest_period;
        logic [11:0] goal_period;
        logic [7:0]  glide_step;
        logic [6:0]  volume;
        logic [4:0]  sample;
        logic [11:0] effect_param;
        logic [15:0] wave_settings;
        logic [15:0] wave_positions;
        logic [15:0] offset;
        logic [8:0]  delay_cut;
        logic [9:0]  loop;
    } chan_t;

    // Search request and answer between the sequencer and the table unit
    typedef struct packed {
        logic        go;
        logic [11:0] period;
    } srch_req_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] idx;
    } srch_rsp_t;

    function automatic logic [10:0] rom_entry(input logic [IDX_W-1:0] i);
        logic [10:0] v;
        unique case (i)
            6'd0: v = 11'd1712;  6'd1: v = 11'd1616;  6'd2: v = 11'd1524;
            6'd3: v = 11'd1440;  6'd4: v = 11'd1356;  6'd5: v = 11'd1280;
            6'd6: v = 11'd1208;  6'd7: v = 11'd1140;  6'd8: v = 11'd1076;
            6'd9: v = 11'd1016;  6'd10: v = 11'd960;  6'd11: v = 11'd906;
            6'd12: v = 11'd856;  6'd13: v = 11'd808;  6'd14: v = 11'd762;
            6'd15: v = 11'd720;  6'd16: v = 11'd678;  6'd17: v = 11'd640;
            6'd18: v = 11'd604;  6'd19: v = 11'd570;  6'd20: v = 11'd538;
            6'd21: v = 11'd508;  6'd22: v = 11'd480;  6'd23: v = 11'd453;
            6'd24: v = 11'd428;  6'd25: v = 11'd404;  6'd26: v = 11'd381;
            6'd27: v = 11'd360;  6'd28: v = 11'd339;  6'd29: v = 11'd320;
            6'd30: v = 11'd302;  6'd31: v = 11'd285;  6'd32: v = 11'd269;
            6'd33: v = 11'd254;  6'd34: v = 11'd240;  6'd35: v = 11'd226;
            6'd36: v = 11'd214;  6'd37: v = 11'd202;  6'd38: v = 11'd190;
            6'd39: v = 11'd180;  6'd40: v = 11'd170;  6'd41: v = 11'd160;
            6'd42: v = 11'd151;  6'd43: v = 11'd143;  6'd44: v = 11'd135;
            6'd45: v = 11'd127;  6'd46: v = 11'd120;  6'd47: v = 11'd113;
            default: v = 11'd113;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] per_clamp(input logic signed [13:0] v);
        if (v < 14'sd113) return PERIOD_MIN;
        if (v > 14'sd1712) return PERIOD_MAX;
        return v[11:0];
    endfunction

    function automatic logic [6:0] vol_clamp(input logic signed [9:0] v);
        if (v < 10'sd0) return 7'd0;
        if (v > 10'sd64) return VOL_MAX;
        return v[6:0];
    endfunction

    function automatic logic signed [5:0] tri_wave(input logic [7:0] pos);
        logic [5:0] ph;
        ph = pos[5:0];
        if (ph < 6'd16) return $signed({1'b0, ph[4:0]});
        if (ph < 6'd48) return 6'sd32 - $signed({1'b0, ph[4:0]}) - (ph[5] ? 6'sd32 : 6'sd0);
        return $signed(ph);
    endfunction

endpackage

>>> design/tcee_search.sv
// Nearest-entry search over the period table, one entry compared per cycle.
// Depends on tcee_pkg.
module tcee_search (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcee_pkg::srch_req_t   req,
    output tcee_pkg::srch_rsp_t   rsp
);

    logic                     run_reg;
    logic [tcee_pkg::IDX_W-1:0] i_reg;
    logic [tcee_pkg::IDX_W-1:0] best_idx_reg;
    logic [11:0]              best_d_reg;
    logic [11:0]              per_reg;
    logic                     done_reg;
    logic [11:0]              e;
    logic [11:0]              d;

    // Distance of the current entry from the wanted period
    assign e = {1'b0, tcee_pkg::rom_entry(i_reg)};
    assign d = (e > per_reg) ? e - per_reg : per_reg - e;

    // Walk the table, keep the first closest entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                run_reg      <= 1'b1;
                i_reg        <= '0;
                per_reg      <= req.period;
                best_d_reg   <= 12'hFFF;
                best_idx_reg <= '0;
            end
            else if (run_reg)
            begin
                if (d < best_d_reg || i_reg == '0)
                begin
                    best_d_reg   <= d;
                    best_idx_reg <= i_reg;
                end
                if (i_reg == tcee_pkg::IDX_W'(tcee_pkg::TLEN - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    i_reg <= i_reg + 1'b1;
            end
        end
    end

    // Final compare folds in on the last step
    always_comb
    begin
        rsp.done = done_reg;
        rsp.idx  = best_idx_reg;
    end

endmodule

>>> design/tracker_channel_effect_engine_core.sv
// Per-channel effect engine: sequencer, channel state and result register.
// Depends on tcee_pkg and tcee_search.
// Row items and most ticks pass through S_EXEC and S_OUT before the result strobe; an
// arpeggio tick also passes through S_SEARCH, a one-entry-per-cycle walk of the 48-entry
// period table. One request at a time: busy is high from acceptance until the strobe
// cycle ends, so a new request is not taken before the last result has been strobed.
// Reset clears all channel state to zero; results are strobed and cannot be stalled.
module tracker_channel_effect_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [1:0]  channel,
    input  logic [4:0]  tick,
    input  logic [5:0]  row,
    input  logic [11:0] note_period,
    input  logic [4:0]  note_sample,
    input  logic [6:0]  sample_volume,
    input  logic [3:0]  effect,
    input  logic [7:0]  parameter_req,
    output logic        done,
    output logic [11:0] out_period,
    output logic [6:0]  out_volume,
    output logic        trigger,
    output logic [4:0]  out_sample,
    output logic [15:0] start_offset,
    output logic [1:0]  jump_kind,
    output logic [7:0]  jump_order,
    output logic [5:0]  jump_row,
    output logic [3:0]  delay_rows,
    output logic [4:0]  new_speed,
    output logic [7:0]  new_tempo
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SEARCH, S_OUT} state_t;

    state_t               state_reg;
    tcee_pkg::chan_t      chans_reg [tcee_pkg::CHANNELS];
    tcee_pkg::chan_t      cur;
    tcee_pkg::chan_t      nx;
    logic                 op_reg;
    logic [1:0]           ch_reg;
    logic [4:0]           tick_reg;
    logic [5:0]           row_reg;
    logic [11:0]          nper_reg;
    logic [4:0]           nsmp_reg;
    logic [6:0]           svol_reg;
    logic [3:0]           eff_reg;
    logic [7:0]           prm_reg;
    logic [3:0]           semi_reg;
    logic                 trig_reg;
    logic [6:0]           vol_reg;
    logic [1:0]           jk_reg;
    logic [7:0]           jo_reg;
    logic [5:0]           jr_reg;
    logic [3:0]           dly_reg;
    logic [4:0]           spd_reg;
    logic [7:0]           tmp_reg;
    logic                 done_reg;
    logic [11:0]          per_o_reg;
    logic [4:0]           smp_o_reg;
    logic [15:0]          off_o_reg;
    tcee_pkg::srch_req_t  sreq;
    tcee_pkg::srch_rsp_t  srsp;

    // Combinational results of one step
    logic        n_trig;
    logic [6:0]  n_vol;
    logic [1:0]  n_jk;
    logic [7:0]  n_jo;
    logic [5:0]  n_jr;
    logic [3:0]  n_dly;
    logic [4:0]  n_spd;
    logic [7:0]  n_tmp;
    logic        n_arp;
    logic [3:0]  n_semi;
    logic [6:0]  arp_sum;
    logic [5:0]  arp_idx;

    tcee_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp)
    );

    assign cur = chans_reg[ch_reg];
    assign sreq.go = (state_reg == S_EXEC) && n_arp;
    assign sreq.period = cur.rest_period;

    // Finish the arpeggio: add semitones and hold at the table end
    assign arp_sum = {1'b0, srsp.idx} + {3'b0, semi_reg};
    assign arp_idx = (arp_sum >= 7'(tcee_pkg::TLEN)) ? 6'(tcee_pkg::TLEN - 1) : arp_sum[5:0];

    // Work out the new channel state and the request fields
    always_comb
    begin
        logic [3:0] sub, x, e, p_sub, p_x;
        logic [7:0] p;
        logic [8:0] dc;
        logic [5:0] lrow;
        logic [3:0] lcnt;
        logic [7:0] pos;
        logic signed [9:0] dl;
        logic signed [13:0] base_s;
        logic [4:0] rmod;
        logic [7:0] r;
        logic [3:0] sv_up, sv_dn;
        logic [8:0] rm9;
        logic [8:0] dv;
        logic [4:0] m3;
        nx = cur;
        n_trig = 1'b0; n_jk = tcee_pkg::JUMP_NONE; n_jo = '0; n_jr = '0;
        n_dly = '0; n_spd = '0; n_tmp = '0; n_arp = 1'b0; n_semi = '0;
        sub = prm_reg[7:4]; x = prm_reg[3:0];
        e = cur.effect_param[11:8]; p = cur.effect_param[7:0];
        p_sub = p[7:4]; p_x = p[3:0];
        dc = cur.delay_cut;
        lrow = cur.loop[9:4]; lcnt = cur.loop[3:0];
        pos = '0; dl = '0; base_s = '0; rmod = '0; r = '0;
        rm9 = '0; dv = '0; m3 = '0;
        sv_up = p_sub; sv_dn = p_x;
        n_vol = cur.volume;
        if (!op_reg)
        begin
            nx.delay_cut = '0;
            nx.effect_param = {eff_reg, prm_reg};
            if (nsmp_reg != 5'd0 && nsmp_reg <= 5'(tcee_pkg::SAMPLES))
            begin
                nx.sample = nsmp_reg;
                nx.volume = tcee_pkg::vol_clamp($signed({3'b0, svol_reg}));
            end
            if (eff_reg == tcee_pkg::EFF_PORTA || eff_reg == tcee_pkg::EFF_PORTA_VS)
            begin
                if (nper_reg != 12'd0) nx.goal_period = nper_reg;
            end
            else if (nper_reg != 12'd0)
            begin
                nx.rest_period = nper_reg;
                nx.period = nper_reg;
                n_trig = 1'b1;
            end
            unique case (eff_reg)
                tcee_pkg::EFF_PORTA: if (prm_reg != 8'd0) nx.glide_step = prm_reg;
                tcee_pkg::EFF_VIB:
                begin
                    if (sub != 4'd0) nx.wave_settings[15:12] = sub;
                    if (x != 4'd0) nx.wave_settings[11:8] = x;
                end
                tcee_pkg::EFF_TREM:
                begin
                    if (sub != 4'd0) nx.wave_settings[7:4] = sub;
                    if (x != 4'd0) nx.wave_settings[3:0] = x;
                end
                tcee_pkg::EFF_OFFSET: if (prm_reg != 8'd0) nx.offset = {prm_reg, 8'd0};
                tcee_pkg::EFF_JUMP:
                begin
                    n_jk = tcee_pkg::JUMP_POS; n_jo = prm_reg;
                end
                tcee_pkg::EFF_VOL: nx.volume = tcee_pkg::vol_clamp($signed({2'b0, prm_reg}));
                tcee_pkg::EFF_BREAK:
                begin
                    r = 8'({sub, 3'b0}) + 8'({sub, 1'b0}) + {4'b0, x};
                    n_jk = tcee_pkg::JUMP_BREAK;
                    n_jr = (r < 8'(tcee_pkg::ROWS)) ? r[5:0] : 6'd0;
                end
                tcee_pkg::EFF_EXT:
                begin
                    unique case (sub)
                        tcee_pkg::EXT_FINE_UP:
                        begin
                            nx.rest_period = tcee_pkg::per_clamp(
                                $signed({2'b0, nx.rest_period}) - $signed({10'b0, x}));
                            nx.period = nx.rest_period;
                        end
                        tcee_pkg::EXT_FINE_DN:
                        begin
                            nx.rest_period = tcee_pkg::per_clamp(
                                $signed({2'b0, nx.rest_period}) + $signed({10'b0, x}));
                            nx.period = nx.rest_period;
                        end
                        tcee_pkg::EXT_LOOP:
                        begin
                            if (x == 4'd0) lrow = row_reg;
                            else if (lcnt == 4'd0)
                            begin
                                lcnt = x; n_jk = tcee_pkg::JUMP_LOOP; n_jr = lrow;
                            end
                            else
                            begin
                                lcnt = lcnt - 4'd1;
                                if (lcnt != 4'd0)
                                begin
                                    n_jk = tcee_pkg::JUMP_LOOP; n_jr = lrow;
                                end
                            end
                            nx.loop = {lrow, lcnt};
                        end
                        tcee_pkg::EXT_FVOL_UP:
                            nx.volume = tcee_pkg::vol_clamp(
                                $signed({3'b0, nx.volume}) + $signed({6'b0, x}));
                        tcee_pkg::EXT_FVOL_DN:
                            nx.volume = tcee_pkg::vol_clamp(
                                $signed({3'b0, nx.volume}) - $signed({6'b0, x}));
                        tcee_pkg::EXT_CUT: nx.delay_cut = {5'b0, x};
                        tcee_pkg::EXT_DELAY:
                        begin
                            nx.delay_cut = {1'b1, x, 4'b0};
                            n_trig = 1'b0;
                        end
                        tcee_pkg::EXT_PDELAY: n_dly = x;
                        default: ;
                    endcase
                end
                tcee_pkg::EFF_SPEED:
                begin
                    if (prm_reg >= 8'd32) n_tmp = prm_reg;
                    else if (prm_reg != 8'd0) n_spd = prm_reg[4:0];
                end
                default: ;
            endcase
            n_vol = nx.volume;
        end
        else
        begin
            if (dc[8] && tick_reg == {1'b0, dc[7:4]})
            begin
                nx.delay_cut = {1'b0, dc[7:0]};
                n_trig = 1'b1;
            end
            if (dc[3:0] != 4'd0 && tick_reg == {1'b0, dc[3:0]}) nx.volume = 7'd0;
            // Retrigger: tick modulo x by shifted compare and subtract
            rm9 = {4'b0, tick_reg};
            for (int k = 4; k >= 0; k--)
            begin
                dv = {5'b0, p_x} << k;
                if (p_x != 4'd0 && rm9 >= dv) rm9 = rm9 - dv;
            end
            rmod = rm9[4:0];
            if (e == tcee_pkg::EFF_EXT && p_sub == tcee_pkg::EXT_RETRIG && p_x != 4'd0
                && rmod == 5'd0) n_trig = 1'b1;
            n_vol = nx.volume;
            // Arpeggio step: tick modulo 3 by shifted compare and subtract
            m3 = tick_reg;
            if (m3 >= 5'd24) m3 = m3 - 5'd24;
            if (m3 >= 5'd12) m3 = m3 - 5'd12;
            if (m3 >= 5'd6) m3 = m3 - 5'd6;
            if (m3 >= 5'd3) m3 = m3 - 5'd3;
            // Porta step and vibrato share these operands
            base_s = $signed({2'b0, cur.rest_period});
            unique case (e)
                tcee_pkg::EFF_ARP:
                begin
                    if (p != 8'd0)
                    begin
                        if (cur.rest_period == 12'd0) nx.period = 12'd0;
                        else
                        begin
                            n_arp = 1'b1;
                            unique case (m3)
                                5'd1: n_semi = p_sub;
                                5'd2: n_semi = p_x;
                                default: n_semi = 4'd0;
                            endcase
                        end
                    end
                end
                tcee_pkg::EFF_SLIDE_UP, tcee_pkg::EFF_SLIDE_DN:
                begin
                    nx.rest_period = tcee_pkg::per_clamp((e == tcee_pkg::EFF_SLIDE_UP)
                        ? base_s - $signed({6'b0, p}) : base_s + $signed({6'b0, p}));
                    nx.period = nx.rest_period;
                end
                tcee_pkg::EFF_PORTA, tcee_pkg::EFF_PORTA_VS:
                begin
                    if (cur.goal_period != 12'd0 && cur.glide_step != 8'd0)
                    begin
                        if (cur.rest_period < cur.goal_period)
                        begin
                            base_s = base_s + $signed({6'b0, cur.glide_step});
                            if (base_s > $signed({2'b0, cur.goal_period}))
                                base_s = $signed({2'b0, cur.goal_period});
                        end
                        else if (cur.rest_period > cur.goal_period)
                        begin
                            base_s = base_s - $signed({6'b0, cur.glide_step});
                            if (base_s < $signed({2'b0, cur.goal_period}))
                                base_s = $signed({2'b0, cur.goal_period});
                        end
                        nx.rest_period = base_s[11:0];
                        nx.period = base_s[11:0];
                    end
                end
                tcee_pkg::EFF_VIB, tcee_pkg::EFF_VIB_VS:
                begin
                    pos = cur.wave_positions[15:8];
                    dl = 10'(tcee_pkg::tri_wave(pos))
                        * $signed({6'b0, cur.wave_settings[11:8]});
                    dl = (dl < 0) ? -((-dl) >>> 3) : dl >>> 3;
                    nx.period = tcee_pkg::per_clamp(base_s + 14'(dl));
                    nx.wave_positions[15:8] = pos + {4'b0, cur.wave_settings[15:12]};
                end
                tcee_pkg::EFF_TREM:
                begin
                    pos = cur.wave_positions[7:0];
                    dl = 10'(tcee_pkg::tri_wave(pos))
                        * $signed({6'b0, cur.wave_settings[3:0]});
                    dl = (dl < 0) ? -((-dl) >>> 4) : dl >>> 4;
                    nx.wave_positions[7:0] = pos + {4'b0, cur.wave_settings[7:4]};
                    n_vol = tcee_pkg::vol_clamp($signed({3'b0, nx.volume}) + dl);
                end
                default: ;
            endcase
            // Volume slide for the combined and plain slide effects
            if (e == tcee_pkg::EFF_PORTA_VS || e == tcee_pkg::EFF_VIB_VS
                || e == tcee_pkg::EFF_VSLIDE)
            begin
                nx.volume = tcee_pkg::vol_clamp((sv_up != 4'd0)
                    ? $signed({3'b0, nx.volume}) + $signed({6'b0, sv_up})
                    : $signed({3'b0, nx.volume}) - $signed({6'b0, sv_dn}));
                n_vol = nx.volume;
            end
        end
    end

    // Sequencer, channel state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int c = 0; c < tcee_pkg::CHANNELS; c++) chans_reg[c] <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        op_reg <= op; ch_reg <= channel; tick_reg <= tick; row_reg <= row;
                        nper_reg <= note_period; nsmp_reg <= note_sample;
                        svol_reg <= sample_volume; eff_reg <= effect; prm_reg <= parameter_req;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    chans_reg[ch_reg] <= nx;
                    trig_reg <= n_trig; vol_reg <= n_vol; jk_reg <= n_jk; jo_reg <= n_jo;
                    jr_reg <= n_jr; dly_reg <= n_dly; spd_reg <= n_spd; tmp_reg <= n_tmp;
                    semi_reg <= n_semi;
                    state_reg <= n_arp ? S_SEARCH : S_OUT;
                end
                S_SEARCH:
                begin
                    if (srsp.done)
                    begin
                        chans_reg[ch_reg].period <= {1'b0, tcee_pkg::rom_entry(arp_idx)};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    per_o_reg <= cur.period; smp_o_reg <= cur.sample; off_o_reg <= cur.offset;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign out_period = per_o_reg;
    assign out_volume = vol_reg;
    assign trigger = trig_reg;
    assign out_sample = smp_o_reg;
    assign start_offset = off_o_reg;
    assign jump_kind = jk_reg;
    assign jump_order = jo_reg;
    assign jump_row = jr_reg;
    assign delay_rows = dly_reg;
    assign new_speed = spd_reg;
    assign new_tempo = tmp_reg;

endmodule

>>> design/tcee_checker.sv
// Port-level checker for the effect engine core, bound to tracker_channel_effect_engine_core.
// Depends on tcee_pkg and the tracker_channel_effect_engine_core ports.
module tcee_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [6:0]  out_volume,
    input logic [1:0]  jump_kind,
    input logic [7:0]  jump_order
);

    // Accepted request makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    // Strobe lasts one cycle
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Volume stays within range on a result
    a_vol: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_volume <= tcee_pkg::VOL_MAX)
        else $error("volume out of range");

    // Order target only with a position jump
    a_jump: assert property (@(posedge clk) disable iff (!rst_n)
        (done && jump_kind != tcee_pkg::JUMP_POS) |-> jump_order == 8'd0)
        else $error("jump order without position jump");

endmodule

bind tracker_channel_effect_engine_core tcee_checker u_tcee_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .out_volume (out_volume),
    .jump_kind  (jump_kind),
    .jump_order (jump_order)
);
